FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the blur core checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is low
`define SGB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same, on the house clock and reset names
`define SGB_CHECK(lbl, prop, msg) `SGB_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

FILE: rtl/sgb_pkg.sv
// ----------------------------------------------------------------------------
// sgb_pkg
// shared types and constants of the separable gaussian blur core
// ----------------------------------------------------------------------------
`default_nettype none

package sgb_pkg;

  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned IDX_W     = 14;
  localparam int unsigned VAL_W     = 24;
  localparam int unsigned PIX_W     = 24;
  localparam int unsigned ROW_W     = 32;
  localparam int unsigned RES_W     = 40;
  localparam int unsigned ACC_W     = 64;
  localparam int unsigned CFG_AW    = 3;
  localparam int unsigned CFG_DW    = 32;
  localparam int unsigned CFG_REG_W = 8;

  localparam logic [CFG_REG_W-1:0] DIM_RESET = 8'd128;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD_TAP = 2'd0,
    FUNC_LOAD_PIX = 2'd1,
    FUNC_READ     = 2'd2,
    FUNC_START    = 2'd3
  } func_e;

  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } cfg_reg_e;

  // control that rides along with one multiply-accumulate term
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic col;
  } mac_ctl_t;

  // write-back strobe of one finished pass value
  typedef struct packed {
    logic valid;
    logic col;
  } wr_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/sgb_mac.sv
// ----------------------------------------------------------------------------
// sgb_mac
// multiply, saturating accumulate and rounding stages shared by both passes
// ----------------------------------------------------------------------------
`default_nettype none

module sgb_mac import sgb_pkg::*; #(
  parameter int unsigned TAP_FRAC_BITS = 18,
  parameter int unsigned ADDR_W        = 14
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire mac_ctl_t                 ctl_i,
  input  wire logic [ADDR_W-1:0]        waddr_i,
  input  wire logic [TAP_FRAC_BITS:0]   tap_i,
  input  wire logic [ROW_W-1:0]         opnd_i,
  output wr_ctl_t                       wr_o,
  output logic      [ADDR_W-1:0]        wr_addr_o,
  output logic      [RES_W-1:0]         wr_data_o,
  output logic                          busy_o
);

  localparam int unsigned PROD_W = TAP_FRAC_BITS + 1 + ROW_W;
  localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (TAP_FRAC_BITS - 1);

  function automatic logic [ACC_W-1:0] sat_add(logic [ACC_W-1:0] a, logic [ACC_W-1:0] b);
    logic [ACC_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ACC_W] ? {ACC_W{1'b1}} : s[ACC_W-1:0];
  endfunction

  mac_ctl_t           ctl2_q;
  logic [ADDR_W-1:0]  waddr2_q;
  logic [PROD_W-1:0]  prod_q;
  logic [ACC_W-1:0]   acc_q;
  logic [ACC_W-1:0]   acc_sum;
  wr_ctl_t            ctl3_q;
  logic [ADDR_W-1:0]  waddr3_q;
  logic [ACC_W-1:0]   fin_q;
  logic [ACC_W-1:0]   rnd;
  logic [ROW_W-1:0]   rnd_row;
  logic [RES_W-1:0]   rnd_res;

  // stage 2: product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl2_q <= '0;
    end else begin
      ctl2_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    waddr2_q <= waddr_i;
    prod_q   <= PROD_W'(tap_i) * PROD_W'(opnd_i);
  end

  // stage 3: accumulate, first term restarts the sum
  assign acc_sum = sat_add(ctl2_q.first ? '0 : acc_q, ACC_W'(prod_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl3_q <= '0;
    end else begin
      ctl3_q.valid <= ctl2_q.valid && ctl2_q.last;
      ctl3_q.col   <= ctl2_q.col;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl2_q.valid) begin
      acc_q <= acc_sum;
    end
    if (ctl2_q.valid && ctl2_q.last) begin
      fin_q    <= acc_sum;
      waddr3_q <= waddr2_q;
    end
  end

  // stage 4: round half up and clamp to the store width
  assign rnd     = sat_add(fin_q, HALF) >> TAP_FRAC_BITS;
  assign rnd_row = (|rnd[ACC_W-1:ROW_W]) ? {ROW_W{1'b1}} : rnd[ROW_W-1:0];
  assign rnd_res = (|rnd[ACC_W-1:RES_W]) ? {RES_W{1'b1}} : rnd[RES_W-1:0];

  assign wr_o      = ctl3_q;
  assign wr_addr_o = waddr3_q;
  assign wr_data_o = ctl3_q.col ? rnd_res : RES_W'(rnd_row);
  assign busy_o    = ctl2_q.valid | ctl3_q.valid;

endmodule

`default_nettype wire

FILE: rtl/separable_gaussian_blur_core.sv
// ----------------------------------------------------------------------------
// separable_gaussian_blur_core
// two-pass separable gaussian filter over on-chip pixel and result stores
// ----------------------------------------------------------------------------
// Each beat carries one command. Tap and pixel loads are taken one per cycle
// while idle with no read pending and go straight into their store. A read
// passes its result through the store read register and then the output
// register, and the block takes the next command once that result is
// registered; a load can go in while a result waits. A start runs the row
// pass and then the column pass through one multiply-accumulate unit fed by
// one read port per store, one term per cycle, draining after each pass, for
// W*H*(W+H) terms over clamped width W and height H; stores need no clearing.
`default_nettype none

module separable_gaussian_blur_core import sgb_pkg::*; #(
  parameter int unsigned MAX_DIM       = 128,
  parameter int unsigned TAP_FRAC_BITS = 18
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [FUNC_W-1:0] func_i,
  input  wire logic [IDX_W-1:0]  item_index_i,
  input  wire logic [VAL_W-1:0]  item_value_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [RES_W-1:0]       filtered_value_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0]      prdata,
  output logic                   pready
);

  localparam int unsigned CELLS  = MAX_DIM * MAX_DIM;
  localparam int unsigned ADDR_W = $clog2(CELLS);
  localparam int unsigned CNT_W  = $clog2(MAX_DIM);
  localparam int unsigned DIM_W  = $clog2(MAX_DIM + 1);
  localparam int unsigned TAP_W  = TAP_FRAC_BITS + 1;

  typedef enum logic [4:0] {
    ST_IDLE      = 5'b00001,
    ST_ROW       = 5'b00010,
    ST_DRAIN_ROW = 5'b00100,
    ST_COL       = 5'b01000,
    ST_DRAIN_COL = 5'b10000
  } state_e;

  function automatic logic [DIM_W-1:0] clamp_dim(logic [CFG_REG_W-1:0] v);
    if (v == '0) begin
      return DIM_W'(1);
    end else if (32'(v) > MAX_DIM) begin
      return DIM_W'(MAX_DIM);
    end else begin
      return DIM_W'(v);
    end
  endfunction

  function automatic logic [CNT_W-1:0] abs_diff(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // configuration registers
  logic [CFG_REG_W-1:0] width_q, height_q;
  cfg_reg_e             cfg_sel;

  assign cfg_sel = cfg_reg_e'(paddr[2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_RESET;
      height_q <= DIM_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (cfg_sel)
        REG_WIDTH:  width_q  <= pwdata[CFG_REG_W-1:0];
        REG_HEIGHT: height_q <= pwdata[CFG_REG_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_WIDTH:  prdata = CFG_DW'(width_q);
      REG_HEIGHT: prdata = CFG_DW'(height_q);
      default:    prdata = '0;
    endcase
  end

  // command decode
  state_e                  st_q, st_d;
  func_e                   func;
  logic                    in_fire;
  logic                    rd_pend_q, rd_zero_q;
  logic                    out_valid_q;
  logic [RES_W-1:0]        out_data_q;
  logic [31:0]             idx_wide;
  logic [31:0]             val_wide;
  logic [ADDR_W-1:0]       idx_addr;
  logic [CNT_W-1:0]        tap_addr;
  logic [TAP_W-1:0]        tap_wdata;
  logic [DIM_W-1:0]        w_eff, h_eff;
  logic [2*DIM_W-1:0]      n_cells;
  logic                    rd_go;

  assign func      = func_e'(func_i);
  assign idx_wide  = 32'(item_index_i);
  assign val_wide  = 32'(item_value_i);
  assign idx_addr  = idx_wide[ADDR_W-1:0];
  assign tap_addr  = idx_wide[CNT_W-1:0];
  assign tap_wdata = (val_wide > (32'(1) << TAP_FRAC_BITS)) ?
                     TAP_W'(32'(1) << TAP_FRAC_BITS) : TAP_W'(val_wide);
  assign w_eff     = clamp_dim(width_q);
  assign h_eff     = clamp_dim(height_q);
  assign n_cells   = (2*DIM_W)'(w_eff) * (2*DIM_W)'(h_eff);

  // a read needs the output register free by the time its data lands
  assign in_ready_o = (st_q == ST_IDLE) && !rd_pend_q &&
                      ((func != FUNC_READ) || !out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;
  assign rd_go      = in_fire && (func == FUNC_READ);

  // sweep counters
  logic [CNT_W-1:0]  i_q, i_d, j_q, j_d, k_q, k_d;
  logic [CNT_W-1:0]  wm1_q, hm1_q, klast;
  logic [ADDR_W-1:0] ibase_q, ibase_d, kbase_q, kbase_d, wstep_q;
  logic              issue, col_pass;
  logic [ADDR_W-1:0] pix_raddr, row_raddr;
  logic [CNT_W-1:0]  tap_dist;

  mac_ctl_t          ctl1_q, ctl1_d;
  logic [ADDR_W-1:0] waddr1_q;
  logic              mac_busy;
  wr_ctl_t           wr;
  logic [ADDR_W-1:0] wr_addr;
  logic [RES_W-1:0]  wr_data;

  assign issue     = (st_q == ST_ROW) || (st_q == ST_COL);
  assign col_pass  = (st_q == ST_COL);
  assign klast     = col_pass ? hm1_q : wm1_q;
  assign pix_raddr = ibase_q + ADDR_W'(k_q);
  assign row_raddr = kbase_q + ADDR_W'(j_q);
  assign tap_dist  = col_pass ? abs_diff(i_q, k_q) : abs_diff(j_q, k_q);

  always_comb begin
    st_d    = st_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    ibase_d = ibase_q;
    kbase_d = kbase_q;

    ctl1_d.valid = issue;
    ctl1_d.first = (k_q == '0);
    ctl1_d.last  = (k_q == klast);
    ctl1_d.col   = col_pass;

    unique case (st_q)
      ST_IDLE: begin
        if (in_fire && (func == FUNC_START)) begin
          st_d    = ST_ROW;
          i_d     = '0;
          j_d     = '0;
          k_d     = '0;
          ibase_d = '0;
          kbase_d = '0;
        end
      end
      ST_ROW: begin
        // row i, output column j, source column k
        if (k_q == wm1_q) begin
          k_d     = '0;
          kbase_d = '0;
          if (j_q == wm1_q) begin
            j_d = '0;
            if (i_q == hm1_q) begin
              i_d     = '0;
              ibase_d = '0;
              st_d    = ST_DRAIN_ROW;
            end else begin
              i_d     = i_q + 1'b1;
              ibase_d = ibase_q + wstep_q;
            end
          end else begin
            j_d = j_q + 1'b1;
          end
        end else begin
          k_d     = k_q + 1'b1;
          kbase_d = kbase_q + wstep_q;
        end
      end
      ST_DRAIN_ROW: begin
        // column pass reads what the row pass writes: wait for the last write
        if (!ctl1_q.valid && !mac_busy && !wr.valid) begin
          st_d = ST_COL;
        end
      end
      ST_COL: begin
        // column j, output row i, source row k
        if (k_q == hm1_q) begin
          k_d     = '0;
          kbase_d = '0;
          if (i_q == hm1_q) begin
            i_d     = '0;
            ibase_d = '0;
            if (j_q == wm1_q) begin
              j_d  = '0;
              st_d = ST_DRAIN_COL;
            end else begin
              j_d = j_q + 1'b1;
            end
          end else begin
            i_d     = i_q + 1'b1;
            ibase_d = ibase_q + wstep_q;
          end
        end else begin
          k_d     = k_q + 1'b1;
          kbase_d = kbase_q + wstep_q;
        end
      end
      ST_DRAIN_COL: begin
        if (!ctl1_q.valid && !mac_busy && !wr.valid) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      ibase_q <= '0;
      kbase_q <= '0;
      wm1_q   <= '0;
      hm1_q   <= '0;
      wstep_q <= '0;
      ctl1_q  <= '0;
    end else begin
      st_q    <= st_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      ibase_q <= ibase_d;
      kbase_q <= kbase_d;
      ctl1_q  <= ctl1_d;
      if (in_fire && (func == FUNC_START)) begin
        wm1_q   <= CNT_W'(w_eff - 1'b1);
        hm1_q   <= CNT_W'(h_eff - 1'b1);
        wstep_q <= ADDR_W'(w_eff);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    waddr1_q <= ibase_q + ADDR_W'(j_q);
  end

  // stores
  logic [TAP_W-1:0] tap_mem  [MAX_DIM];
  logic [PIX_W-1:0] pix_mem  [CELLS];
  logic [ROW_W-1:0] rowp_mem [CELLS];
  logic [RES_W-1:0] res_mem  [CELLS];

  logic [TAP_W-1:0] tap_rd_q;
  logic [PIX_W-1:0] pix_rd_q;
  logic [ROW_W-1:0] rowp_rd_q;
  logic [RES_W-1:0] res_rd_q;

  always_ff @(posedge clk_i) begin
    if (in_fire && (func == FUNC_LOAD_TAP) && (idx_wide < MAX_DIM)) begin
      tap_mem[tap_addr] <= tap_wdata;
    end
    if (issue) begin
      tap_rd_q <= tap_mem[tap_dist];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && (func == FUNC_LOAD_PIX) && (idx_wide < CELLS)) begin
      pix_mem[idx_addr] <= item_value_i;
    end
    if (issue) begin
      pix_rd_q <= pix_mem[pix_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr.valid && !wr.col) begin
      rowp_mem[wr_addr] <= wr_data[ROW_W-1:0];
    end
    if (issue) begin
      rowp_rd_q <= rowp_mem[row_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr.valid && wr.col) begin
      res_mem[wr_addr] <= wr_data;
    end
    if (rd_go) begin
      res_rd_q <= res_mem[idx_addr];
    end
  end

  sgb_mac #(
    .TAP_FRAC_BITS (TAP_FRAC_BITS),
    .ADDR_W        (ADDR_W)
  ) u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl1_q),
    .waddr_i   (waddr1_q),
    .tap_i     (tap_rd_q),
    .opnd_i    (ctl1_q.col ? rowp_rd_q : ROW_W'(pix_rd_q)),
    .wr_o      (wr),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .busy_o    (mac_busy)
  );

  // read result path
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_pend_q <= rd_go;
      if (rd_pend_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_go) begin
      rd_zero_q <= !(idx_wide < 32'(n_cells));
    end
    if (rd_pend_q) begin
      out_data_q <= rd_zero_q ? '0 : res_rd_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign filtered_value_o = out_data_q;

endmodule

`default_nettype wire

FILE: rtl/sgb_checker.sv
// ----------------------------------------------------------------------------
// sgb_checker
// port-level checks of the blur core command and result channels
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sgb_checker import sgb_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire logic [FUNC_W-1:0] func_i,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire logic [RES_W-1:0]  filtered_value_o
);

  // a stalled result beat holds
  `SGB_CHECK(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(filtered_value_o), "result beat dropped or changed while stalled")

  // every new result beat comes from an earlier read
  `SGB_CHECK(a_out_from_read, $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && (func_i == FUNC_READ), 2), "result beat without a read")

  // a read is never taken while an untaken result would be overwritten
  `SGB_CHECK(a_read_room, in_valid_i && in_ready_o && (func_i == FUNC_READ) |-> !out_valid_o || out_ready_i, "read taken with output register full")

  // start and read both close the command channel for the next cycle
  `SGB_CHECK(a_busy_after, in_valid_i && in_ready_o && ((func_i == FUNC_START) || (func_i == FUNC_READ)) |=> !in_ready_o, "command taken right after start or read")

endmodule

bind separable_gaussian_blur_core sgb_checker u_sgb_checker (.*);

`default_nettype wire
